/* design/kemn_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the key-event to note-message block.
// No dependencies; every other design file imports this package.
package kemn_pkg;

  // Note keys on the keyboard row and their ASCII codes
  localparam int KEY_COUNT = 17;
  localparam logic [7:0] KEY_TABLE [KEY_COUNT] = '{
    8'h61, 8'h77, 8'h73, 8'h65, 8'h64, 8'h66, 8'h74, 8'h67, 8'h79,
    8'h68, 8'h75, 8'h6A, 8'h6B, 8'h6F, 8'h6C, 8'h70, 8'h3B
  };

  // Control keys
  localparam logic [7:0] KEY_TOGGLE  = 8'h6D;  // 'm'
  localparam logic [7:0] KEY_OCT_DN  = 8'h7A;  // 'z'
  localparam logic [7:0] KEY_OCT_UP  = 8'h78;  // 'x'
  localparam logic [7:0] KEY_VEL_DN  = 8'h63;  // 'c'
  localparam logic [7:0] KEY_VEL_UP  = 8'h76;  // 'v'

  // Item kinds
  localparam logic ACT_PRESS  = 1'b0;
  localparam logic ACT_CHANGE = 1'b1;

  localparam int VELOCITY_STEP = 10;
  localparam int SEMITONES     = 12;
  localparam int NOTE_COUNT    = 128;
  localparam int NOTE_W        = 7;
  localparam int VEL_W         = 7;
  localparam int OCT_W         = 4;
  localparam int BASE_W        = 8;   // 12 * octave fits in 8 bits
  localparam int MAX_OUT       = 17;  // messages kept per item
  localparam int CNT_W         = $clog2(MAX_OUT + 1);

  // Sounding map is scanned in chunks
  localparam int CHUNK_W    = 16;
  localparam int NUM_CHUNKS = NOTE_COUNT / CHUNK_W;
  localparam int CHUNK_IW   = $clog2(NUM_CHUNKS);
  localparam int BIT_IW     = $clog2(CHUNK_W);

  localparam int QUEUE_DEPTH_DEF = 4;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_OCT_FLOOR = 2'd0,
    CFG_OCT_CEIL  = 2'd1,
    CFG_VEL_FLOOR = 2'd2,
    CFG_VEL_CEIL  = 2'd3
  } kemn_cfg_e;

  // Work handed from front to back
  typedef struct packed {
    logic                  refresh;  // 0: just a bare result
    logic                  claimed;
    logic [KEY_COUNT-1:0]  keys;     // held keys, zero to release all
    logic [BASE_W-1:0]     base;     // 12 * octave
    logic [VEL_W-1:0]      vel;
  } kemn_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } kemn_q_status_t;

  typedef struct packed {
    logic              note_valid;
    logic [NOTE_W-1:0] note_number;
    logic [VEL_W-1:0]  note_velocity;
    logic              note_on;
    logic              claimed;
    logic              last;
  } kemn_result_t;

endpackage

/* design/key_events_to_midi_notes.sv */
`timescale 1ns / 1ps
// Keyboard-event to note-message converter, top level.
// Instantiates kemn_front, kemn_queue and kemn_back; depends on kemn_pkg.
//
// Input channel (in_valid_i / in_stall_o): one item per keyboard event, either a
// key press (action 0: key_char, key_is_plain) or a held-key map (action 1).
// Output channel (out_valid_o / out_stall_i): one or more result items per
// input item, the final one flagged by last_o. An item with no note message
// still gives one result with note_valid_o low.
// Config: cfg_we_i with cfg_index_i (octave floor/ceiling, velocity
// floor/ceiling) writes one register per edge; write only while idle.
//
// A bare result is registered in the back-end output register once the job,
// written into the queue on acceptance, is popped by the idle back end.
// Setting-only presses give just that bare result; a state change or
// release takes a load step, a step per empty 16-note chunk passed in the off
// and on scans, and a step per message (up to 17 messages).
// A job queue (QUEUE_DEPTH entries) lets items be accepted while the back end
// scans; in_stall_o rises only when it is full.
// Reset: disabled, octave 5, velocity 100, no notes sounding, registers at
// their defaults. A stalled receiver holds the output register and the scan.
module key_events_to_midi_notes import kemn_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [7:0]           key_char_i,
  input  logic                 key_is_plain_i,
  input  logic [KEY_COUNT-1:0] keys_down_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 note_valid_o,
  output logic [NOTE_W-1:0]    note_number_o,
  output logic [VEL_W-1:0]     note_velocity_o,
  output logic                 note_on_o,
  output logic                 claimed_o,
  output logic                 last_o,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [VEL_W-1:0]     cfg_data_i
);

  kemn_job_t      push_job, head_job;
  logic           push, pop;
  kemn_q_status_t q_status;
  kemn_result_t   result;

  // front: settings state and classification of each item
  kemn_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .key_char_i     (key_char_i),
    .key_is_plain_i (key_is_plain_i),
    .keys_down_i    (keys_down_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .q_status_i     (q_status),
    .push_o         (push),
    .job_o          (push_job)
  );

  // jobs carry their own octave and velocity snapshot
  kemn_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .head_o   (head_job),
    .status_o (q_status)
  );

  // back: note map diff, offs then ons in ascending order
  kemn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_job),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign note_valid_o    = result.note_valid;
  assign note_number_o   = result.note_number;
  assign note_velocity_o = result.note_velocity;
  assign note_on_o       = result.note_on;
  assign claimed_o       = result.claimed;
  assign last_o          = result.last;

endmodule

/* design/kemn_front.sv */
`timescale 1ns / 1ps
// Front part: accepts items, holds enable/octave/velocity and config registers,
// and turns each item into one job for the queue. Depends on kemn_pkg.
module kemn_front import kemn_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 action_i,
  input  logic [7:0]           key_char_i,
  input  logic                 key_is_plain_i,
  input  logic [KEY_COUNT-1:0] keys_down_i,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [VEL_W-1:0]     cfg_data_i,
  input  kemn_q_status_t       q_status_i,
  output logic                 push_o,
  output kemn_job_t            job_o
);

  logic [OCT_W-1:0] oct_floor_q, oct_ceil_q;
  logic [VEL_W-1:0] vel_floor_q, vel_ceil_q;
  logic             enabled_q, enabled_d;
  logic [OCT_W-1:0] octave_q, octave_d;
  logic [VEL_W-1:0] velocity_q, velocity_d;

  logic              accept;
  logic signed [5:0] oct_try, oct_lim;
  logic signed [8:0] vel_try, vel_lim;
  logic              is_note_key;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;
  assign push_o     = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oct_floor_q <= '0;
      oct_ceil_q  <= OCT_W'(10);
      vel_floor_q <= VEL_W'(1);
      vel_ceil_q  <= VEL_W'(127);
    end else if (cfg_we_i) begin
      unique case (kemn_cfg_e'(cfg_index_i))
        CFG_OCT_FLOOR: oct_floor_q <= cfg_data_i[OCT_W-1:0];
        CFG_OCT_CEIL:  oct_ceil_q  <= cfg_data_i[OCT_W-1:0];
        CFG_VEL_FLOOR: vel_floor_q <= cfg_data_i;
        CFG_VEL_CEIL:  vel_ceil_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // limited steps: clamp to the floor first, else to the ceiling
  always_comb begin
    oct_try = $signed({2'b00, octave_q}) + ((key_char_i == KEY_OCT_UP) ? 6'sd1 : -6'sd1);
    if (oct_try < $signed({2'b00, oct_floor_q}))     oct_lim = $signed({2'b00, oct_floor_q});
    else if (oct_try > $signed({2'b00, oct_ceil_q})) oct_lim = $signed({2'b00, oct_ceil_q});
    else                                              oct_lim = oct_try;

    vel_try = $signed({2'b00, velocity_q}) +
              ((key_char_i == KEY_VEL_UP) ? 9'(VELOCITY_STEP) : -9'(VELOCITY_STEP));
    if (vel_try < $signed({2'b00, vel_floor_q}))     vel_lim = $signed({2'b00, vel_floor_q});
    else if (vel_try > $signed({2'b00, vel_ceil_q})) vel_lim = $signed({2'b00, vel_ceil_q});
    else                                              vel_lim = vel_try;
  end

  always_comb begin
    is_note_key = 1'b0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      if (KEY_TABLE[i] == key_char_i) is_note_key = 1'b1;
    end
  end

  always_comb begin
    enabled_d   = enabled_q;
    octave_d    = octave_q;
    velocity_d  = velocity_q;
    job_o.refresh = 1'b0;
    job_o.claimed = 1'b0;
    job_o.keys    = '0;
    job_o.base    = BASE_W'({octave_q, 3'b000}) + BASE_W'({octave_q, 2'b00});
    job_o.vel     = velocity_q;
    if (accept) begin
      if (action_i == ACT_CHANGE) begin
        job_o.refresh = 1'b1;
        job_o.keys    = enabled_q ? keys_down_i : '0;
      end else if (key_is_plain_i) begin
        if (key_char_i == KEY_TOGGLE) begin
          job_o.claimed = 1'b1;
          enabled_d     = !enabled_q;
          job_o.refresh = enabled_q;  // turning off releases everything
        end else if (enabled_q) begin
          if (key_char_i == KEY_OCT_DN || key_char_i == KEY_OCT_UP) begin
            job_o.claimed = 1'b1;
            if (oct_lim[OCT_W-1:0] != octave_q) begin
              job_o.refresh = 1'b1;
              octave_d      = oct_lim[OCT_W-1:0];
            end
          end else if (key_char_i == KEY_VEL_DN || key_char_i == KEY_VEL_UP) begin
            job_o.claimed = 1'b1;
            velocity_d    = vel_lim[VEL_W-1:0];
          end else if (is_note_key) begin
            job_o.claimed = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q  <= 1'b0;
      octave_q   <= OCT_W'(5);
      velocity_q <= VEL_W'(100);
    end else begin
      enabled_q  <= enabled_d;
      octave_q   <= octave_d;
      velocity_q <= velocity_d;
    end
  end

endmodule

/* design/kemn_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front and back parts.
// Depends on kemn_pkg for the job and status types.
module kemn_queue import kemn_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  kemn_job_t      job_i,
  input  logic           pop_i,
  output kemn_job_t      head_o,
  output kemn_q_status_t status_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_QW = $clog2(DEPTH + 1);

  kemn_job_t         mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_QW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == CNT_QW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign head_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i)      count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= job_i;
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && status_o.full)) else $error("queue pushed while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && status_o.empty)) else $error("queue popped while empty");

endmodule

/* design/kemn_back.sv */
`timescale 1ns / 1ps
// Back part: owns the sounding-note map, diffs it with each job's wanted map
// and emits notes one per cycle unless stalled or scanning. Uses kemn_pkg.
module kemn_back import kemn_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  kemn_job_t      head_i,
  input  kemn_q_status_t q_status_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output kemn_result_t   result_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_OFF  = 3'b010,
    ST_ON   = 3'b100
  } kemn_back_state_e;

  localparam int SHIFT_W = 256;

  kemn_back_state_e      state_q, state_d;
  logic [NOTE_COUNT-1:0] sounding_q, sounding_d;
  logic [NOTE_COUNT-1:0] off_q, off_d, on_q, on_d;
  logic [CHUNK_IW-1:0]   chunk_q, chunk_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [VEL_W-1:0]      vel_q, vel_d;
  logic                  claimed_q, claimed_d;
  logic                  out_valid_q, out_valid_d;
  kemn_result_t          res_q, res_d;

  logic                  out_free;
  logic [SHIFT_W-1:0]    shifted;
  logic [NOTE_COUNT-1:0] wanted, diff_off, diff_on;
  logic [NOTE_COUNT-1:0] cur_vec, off_rest, on_rest;
  logic [CHUNK_W-1:0]    cur_chunk;
  logic [BIT_IW-1:0]     low_bit;
  logic [NOTE_W-1:0]     note;
  logic                  is_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_status_i.empty && out_free;

  // wanted map: held keys moved up by the base note, overflow folds onto 127
  assign shifted  = {{(SHIFT_W - KEY_COUNT){1'b0}}, head_i.keys} << head_i.base;
  assign wanted   = {|shifted[SHIFT_W-1:NOTE_COUNT-1], shifted[NOTE_COUNT-2:0]};
  assign diff_off = sounding_q & ~wanted;
  assign diff_on  = wanted & ~sounding_q;

  assign cur_vec   = (state_q == ST_ON) ? on_q : off_q;
  assign cur_chunk = cur_vec[chunk_q*CHUNK_W +: CHUNK_W];

  always_comb begin
    low_bit = '0;
    for (int j = CHUNK_W - 1; j >= 0; j--) begin
      if (cur_chunk[j]) low_bit = BIT_IW'(j);
    end
  end

  assign note = {chunk_q, low_bit};

  always_comb begin
    off_rest = off_q;
    on_rest  = on_q;
    if (state_q == ST_ON) on_rest[note] = 1'b0;
    else                  off_rest[note] = 1'b0;
    is_last = (cnt_q == CNT_W'(MAX_OUT - 1)) || !(|off_rest || |on_rest);
  end

  always_comb begin
    state_d     = state_q;
    sounding_d  = sounding_q;
    off_d       = off_q;
    on_d        = on_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    vel_d       = vel_q;
    claimed_d   = claimed_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      ST_IDLE: begin
        if (pop_o) begin
          if (!head_i.refresh || !(|diff_off || |diff_on)) begin
            res_d         = '0;
            res_d.claimed = head_i.claimed;
            res_d.last    = 1'b1;
            out_valid_d   = 1'b1;
          end else begin
            state_d = ST_OFF;
          end
          if (head_i.refresh) begin
            sounding_d = wanted;
            off_d      = diff_off;
            on_d       = diff_on;
          end
          chunk_d   = '0;
          cnt_d     = '0;
          vel_d     = head_i.vel;
          claimed_d = head_i.claimed;
        end
      end
      ST_OFF, ST_ON: begin
        if (out_free) begin
          if (|cur_chunk) begin
            off_d               = off_rest;
            on_d                = on_rest;
            cnt_d               = cnt_q + 1'b1;
            res_d.note_valid    = 1'b1;
            res_d.note_number   = note;
            res_d.note_on       = (state_q == ST_ON);
            res_d.note_velocity = (state_q == ST_ON) ? vel_q : '0;
            res_d.claimed       = claimed_q;
            res_d.last          = is_last;
            out_valid_d         = 1'b1;
            if (is_last) state_d = ST_IDLE;
          end else if (chunk_q == CHUNK_IW'(NUM_CHUNKS - 1)) begin
            chunk_d = '0;
            state_d = (state_q == ST_OFF) ? ST_ON : ST_IDLE;
          end else begin
            chunk_d = chunk_q + 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sounding_q  <= '0;
      chunk_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sounding_q  <= sounding_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    off_q     <= off_d;
    on_q      <= on_d;
    vel_q     <= vel_d;
    claimed_q <= claimed_d;
    res_q     <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  a_offs_before_ons: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ON) |-> (off_q == '0)) else $error("note-on phase with offs pending");

  a_off_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.note_valid && !res_q.note_on) |-> (res_q.note_velocity == '0))
    else $error("note-off with nonzero velocity");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_OUT)) else $error("message count past limit");

endmodule
